// ===== rtl/cubic_bspline_evaluator_unit_macros.svh =====
// Assertion macros shared by the cubic B-spline evaluator RTL.
// Each macro expects signals named clk and rst_n in the including scope.
`ifndef CUBIC_BSPLINE_EVALUATOR_UNIT_MACROS_SVH
`define CUBIC_BSPLINE_EVALUATOR_UNIT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define CBE_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define CBE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define CBE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/cbe_pkg.sv =====
// Shared types and constants of the cubic B-spline evaluator.
// No dependencies; every RTL module imports this package.
package cbe_pkg;

  localparam int QDEPTH = 4;
  localparam int QCNT_W = 3;
  localparam int QPTR_W = 2;
  localparam int SEG_W  = 16;
  localparam int U_W    = 25;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_EVAL = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ORD_VALUE  = 2'd0,
    ORD_FIRST  = 2'd1,
    ORD_SECOND = 2'd2,
    ORD_HIGH   = 2'd3
  } order_t;

  localparam logic [1:0] REG_START = 2'd0;
  localparam logic [1:0] REG_RATE  = 2'd1;
  localparam logic [1:0] REG_COUNT = 2'd2;

  localparam logic [U_W-1:0] ONE_Q24  = 25'h100_0000;
  localparam logic [63:0]    MAG_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0]    HALF_DIV = 64'd50331648;  // 3 * 2^24
  localparam logic [16:0]    THIRD_18 = 17'd87381;     // floor(2^18 / 3)
  localparam logic [19:0]    RECIP3   = 20'd699051;    // ceil(2^21 / 3)
  localparam int             RECIP_SH = 21;

  // One item as it travels from the front end to the back end.
  typedef struct packed {
    logic              is_load;
    logic [7:0]        idx;
    logic [2:0][31:0]  coord;
    logic              rng;
    logic [1:0]        order;
    logic [SEG_W-1:0]  seg;
    logic [U_W-1:0]    u;
  } qent_t;

  // Control that follows an evaluation down the back-end pipeline.
  typedef struct packed {
    logic       vld;
    logic       rng;
    logic [1:0] order;
  } bctl_t;

endpackage

// ===== rtl/cbe_queue.sv =====
// Four-entry item queue between the front end and the back end.
// Depends on cbe_pkg and the assertion macro header.
`include "cubic_bspline_evaluator_unit_macros.svh"

module cbe_queue import cbe_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  qent_t             push_data,
  input  logic              pop,
  output qent_t             head,
  output logic [QCNT_W-1:0] count
);

  qent_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r;
  logic [QPTR_W-1:0]  rd_ptr_r;
  logic [QCNT_W-1:0]  cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (!push && pop) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  assign head  = mem_r[rd_ptr_r];
  assign count = cnt_r;

  `CBE_ASSERT_ALWAYS(a_q_bound, cnt_r <= QCNT_W'(QDEPTH), "queue count above depth")
  `CBE_ASSERT_IMPL(a_q_credit, push && !pop, cnt_r < QCNT_W'(QDEPTH), "push into full queue")
  `CBE_ASSERT_NEXT(a_q_grow, push && !pop, cnt_r == $past(cnt_r) + 1'b1, "queue count lost a push")

endmodule

// ===== rtl/cbe_scale.sv =====
// Two-stage multiply of a Q16 magnitude by the Q16.16 knot rate, rounded and saturated.
// Depends on cbe_pkg.
module cbe_scale import cbe_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] m_i,
  input  logic [31:0] rate,
  output logic [63:0] m_o
);

  logic [62:0] hi_r;
  logic [63:0] lo_r;
  logic [63:0] res_r;
  logic [48:0] lo_rnd;
  logic [64:0] sum;
  logic        sat;

  assign lo_rnd = 49'((lo_r + 64'h8000) >> 16);
  assign sum    = 65'({hi_r[46:0], 16'h0000}) + 65'(lo_rnd);
  assign sat    = (|hi_r[62:47]) || (|sum[64:63]);

  always_ff @(posedge clk) begin
    if (en) begin
      hi_r  <= 63'(m_i[62:32]) * 63'(rate);
      lo_r  <= 64'(m_i[31:0]) * 64'(rate);
      res_r <= sat ? MAG_MAX : sum[63:0];
    end
  end

  assign m_o = res_r;

endmodule

// ===== rtl/cbe_front.sv =====
// Front end: accepts items, forms the knot parameter, range flag, segment and u.
// Depends on cbe_pkg; feeds cbe_queue.
module cbe_front import cbe_pkg::*; #(
  parameter int MAX_POINTS = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_cmd,
  input  logic [7:0]         in_point_index,
  input  logic signed [31:0] in_coord_0,
  input  logic signed [31:0] in_coord_1,
  input  logic signed [31:0] in_coord_2,
  input  logic signed [47:0] in_sample_time,
  input  logic [1:0]         in_deriv_order,
  input  logic signed [47:0] start_time,
  input  logic [31:0]        knot_rate,
  input  logic [8:0]         point_count,
  input  logic [QCNT_W-1:0]  q_count,
  output logic               q_push,
  output qent_t              q_data
);

  logic                acc;
  logic [QCNT_W-1:0]   busy;
  logic signed [48:0]  diff;
  logic [8:0]          cnt;

  logic                a_vld_r, b_vld_r;
  logic                a_load_r, b_load_r;
  logic [7:0]          a_idx_r, b_idx_r;
  logic [2:0][31:0]    a_coord_r, b_coord_r;
  logic [1:0]          a_order_r, b_order_r;
  logic                a_bad_r, b_bad_r;
  logic [31:0]         a_dh_r;
  logic [15:0]         a_dl_r;
  logic [63:0]         b_ph_r;
  logic [47:0]         b_pl_r;

  logic [63:0]         s;
  logic [31:0]         fl;
  logic [31:0]         cm2;
  logic                ovf, lo, hi, clamp;

  assign busy     = q_count + QCNT_W'(a_vld_r) + QCNT_W'(b_vld_r);
  assign in_ready = busy < QCNT_W'(QDEPTH);
  assign acc      = in_valid && in_ready;
  assign diff     = $signed({in_sample_time[47], in_sample_time})
                  - $signed({start_time[47], start_time});
  assign cnt      = (32'(point_count) > MAX_POINTS) ? 9'(MAX_POINTS) : point_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      a_vld_r <= acc;
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    a_load_r  <= (in_cmd == CMD_LOAD);
    a_idx_r   <= in_point_index;
    a_coord_r <= {in_coord_2, in_coord_1, in_coord_0};
    a_order_r <= in_deriv_order;
    a_bad_r   <= diff[48] || (cnt < 9'd4);
    a_dh_r    <= diff[47:16];
    a_dl_r    <= diff[15:0];

    b_load_r  <= a_load_r;
    b_idx_r   <= a_idx_r;
    b_coord_r <= a_coord_r;
    b_order_r <= a_order_r;
    b_bad_r   <= a_bad_r;
    b_ph_r    <= 64'(a_dh_r) * 64'(knot_rate);
    b_pl_r    <= 48'(a_dl_r) * 48'(knot_rate);
  end

  // s is the knot parameter in unsigned Q.32.
  assign ovf   = |b_ph_r[63:47];
  assign s     = 64'({b_ph_r[46:0], 16'h0000}) + 64'(b_pl_r);
  assign fl    = s[63:32];
  assign cm2   = 32'(cnt) - 32'd2;
  assign lo    = (fl == 32'd0);
  assign hi    = (fl > cm2) || ((fl == cm2) && (|s[31:0]));
  // At the top end of the range the segment is pulled back one and u becomes one.
  assign clamp = (fl == cm2);

  assign q_push         = b_vld_r;
  assign q_data.is_load = b_load_r;
  assign q_data.idx     = b_idx_r;
  assign q_data.coord   = b_coord_r;
  assign q_data.rng     = !b_bad_r && !ovf && !lo && !hi;
  assign q_data.order   = b_order_r;
  assign q_data.seg     = clamp ? SEG_W'(cnt - 9'd4) : SEG_W'(fl - 32'd1);
  assign q_data.u       = clamp ? ONE_Q24 : {1'b0, s[31:8]};

endmodule

// ===== rtl/cbe_back.sv =====
// Back end: control point banks, basis weights, weighted sums, rounding and rate scaling.
// Depends on cbe_pkg and cbe_scale; drains cbe_queue.
module cbe_back import cbe_pkg::*; #(
  parameter int MAX_POINTS = 256,
  parameter int DIM        = 3
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [QCNT_W-1:0]  q_count,
  input  qent_t              q_data,
  output logic               q_pop,
  input  logic [31:0]        knot_rate,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_in_range,
  output logic signed [63:0] out_value_0,
  output logic signed [63:0] out_value_1,
  output logic signed [63:0] out_value_2
);

  localparam int IW  = $clog2(MAX_POINTS);
  localparam int BD  = (MAX_POINTS + 3) / 4;
  localparam int BAW = (BD > 1) ? $clog2(BD) : 1;
  localparam int MW  = DIM * 32;
  localparam int NS  = 15;

  logic              adv;
  logic              o_vld_r;
  logic              o_rng_r;
  logic [63:0]       o_val_r [DIM];
  bctl_t             c_r [1:NS];
  bctl_t             c_new;
  logic [IW-1:0]     sg;
  logic              wr_ok;

  logic [MW-1:0]     rd_r [4];
  logic [U_W-1:0]    u1_r, u2_r, u3_r;
  logic [1:0]        sl1_r;
  logic [49:0]       uu2_r;
  logic [U_W-1:0]    sq3_r;
  logic [49:0]       cu3_r;
  logic signed [30:0] w4_r [4];
  logic signed [30:0] wu, wu2, wu3, wone;
  logic signed [30:0] wc [4];

  assign adv   = !o_vld_r || out_ready;
  assign q_pop = adv && (q_count != '0);
  assign sg    = q_data.seg[IW-1:0];
  assign wr_ok = q_pop && q_data.is_load && (32'(q_data.idx) < MAX_POINTS);

  assign c_new.vld   = q_pop && !q_data.is_load;
  assign c_new.rng   = q_data.rng;
  assign c_new.order = q_data.order;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 1; i <= NS; i++) c_r[i] <= '0;
      o_vld_r <= 1'b0;
    end else if (adv) begin
      c_r[1] <= c_new;
      for (int i = 2; i <= NS; i++) c_r[i] <= c_r[i-1];
      o_vld_r <= c_r[NS].vld;
    end
  end

  // Points are spread over four banks by index modulo four, so the four
  // consecutive points of a segment come from four different banks.
  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [MW-1:0]  mem [BD];
    logic [1:0]     off;
    logic [BAW-1:0] raddr;
    logic [BAW-1:0] waddr;

    assign off   = 2'(b) - sg[1:0];
    assign raddr = BAW'(((IW+1)'(sg) + (IW+1)'(off)) >> 2);
    assign waddr = BAW'(q_data.idx >> 2);

    always_ff @(posedge clk) begin
      if (wr_ok && (q_data.idx[1:0] == 2'(b))) mem[waddr] <= MW'(q_data.coord);
      if (adv) rd_r[b] <= mem[raddr];
    end
  end

  // Powers of u, Q24.
  always_ff @(posedge clk) begin
    if (adv) begin
      u1_r  <= q_data.u;
      sl1_r <= sg[1:0];
      uu2_r <= 50'(u1_r) * 50'(u1_r);
      u2_r  <= u1_r;
      sq3_r <= uu2_r[48:24];
      cu3_r <= 50'(uu2_r[48:24]) * 50'(u2_r);
      u3_r  <= u2_r;
    end
  end

  assign wu   = $signed({6'b0, u3_r});
  assign wu2  = $signed({6'b0, sq3_r});
  assign wu3  = $signed({6'b0, cu3_r[48:24]});
  assign wone = $signed({6'b0, ONE_Q24});

  // Six times the basis weight, or its first or second derivative.
  always_comb begin
    case (c_r[3].order)
      ORD_VALUE: begin
        wc[0] = -wu3 + 31'sd3 * wu2 - 31'sd3 * wu + wone;
        wc[1] = 31'sd3 * wu3 - 31'sd6 * wu2 + 31'sd4 * wone;
        wc[2] = -31'sd3 * wu3 + 31'sd3 * wu2 + 31'sd3 * wu + wone;
        wc[3] = wu3;
      end
      ORD_FIRST: begin
        wc[0] = -31'sd3 * wu2 + 31'sd6 * wu - 31'sd3 * wone;
        wc[1] = 31'sd9 * wu2 - 31'sd12 * wu;
        wc[2] = -31'sd9 * wu2 + 31'sd6 * wu + 31'sd3 * wone;
        wc[3] = 31'sd3 * wu2;
      end
      default: begin
        wc[0] = -31'sd6 * wu + 31'sd6 * wone;
        wc[1] = 31'sd18 * wu - 31'sd12 * wone;
        wc[2] = -31'sd18 * wu + 31'sd6 * wone;
        wc[3] = 31'sd6 * wu;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) w4_r[k] <= wc[k];
    end
  end

  for (genvar j = 0; j < DIM; j++) begin : g_lane
    logic signed [31:0] p2_r [4];
    logic signed [31:0] p3_r [4];
    logic signed [31:0] p4_r [4];
    logic signed [62:0] pr5_r [4];
    logic signed [63:0] ps6_r [2];
    logic signed [63:0] sm7_r;
    logic [63:0]        mg8_r;
    logic [35:0]        z9_r;
    logic [34:0]        pa10_r;
    logic [38:0]        qc10_r;
    logic [63:0]        m11_r;
    logic [63:0]        m13, m15;
    logic [63:0]        m0d_r [12:15];
    logic [63:0]        m1d_r [14:15];
    logic               ng_r [8:15];
    logic [18:0]        c10;
    logic [63:0]        sel;

    // The weighted sum stays below 2^61 in magnitude, so the rounded
    // quotient by two fits in 36 bits. Division by three splits the
    // quotient at bit 18, using 2^18 = 3 * 87381 + 1.
    assign c10 = 19'(z9_r[35:18]) + 19'(z9_r[17:0]);

    always_ff @(posedge clk) begin
      if (adv) begin
        for (int k = 0; k < 4; k++) begin
          p2_r[k]  <= $signed(rd_r[2'(sl1_r + 2'(k))][j*32 +: 32]);
          p3_r[k]  <= p2_r[k];
          p4_r[k]  <= p3_r[k];
          pr5_r[k] <= 63'(w4_r[k]) * 63'(p4_r[k]);
        end
        ps6_r[0] <= 64'(pr5_r[0]) + 64'(pr5_r[1]);
        ps6_r[1] <= 64'(pr5_r[2]) + 64'(pr5_r[3]);
        sm7_r    <= ps6_r[0] + ps6_r[1];
        ng_r[8]  <= sm7_r[63];
        mg8_r    <= sm7_r[63] ? 64'(-sm7_r) : 64'(sm7_r);
        z9_r     <= 36'((mg8_r + HALF_DIV) >> 25);
        pa10_r   <= 35'(z9_r[35:18]) * 35'(THIRD_18);
        qc10_r   <= 39'(c10) * 39'(RECIP3);
        m11_r    <= 64'(pa10_r) + 64'(qc10_r >> RECIP_SH);
        m0d_r[12] <= m11_r;
        for (int i = 13; i <= 15; i++) m0d_r[i] <= m0d_r[i-1];
        m1d_r[14] <= m13;
        m1d_r[15] <= m1d_r[14];
        for (int i = 9; i <= 15; i++) ng_r[i] <= ng_r[i-1];
      end
    end

    cbe_scale u_scale1 (
      .clk  (clk),
      .en   (adv),
      .m_i  (m11_r),
      .rate (knot_rate),
      .m_o  (m13)
    );

    cbe_scale u_scale2 (
      .clk  (clk),
      .en   (adv),
      .m_i  (m13),
      .rate (knot_rate),
      .m_o  (m15)
    );

    always_comb begin
      case (c_r[NS].order)
        ORD_VALUE: sel = m0d_r[15];
        ORD_FIRST: sel = m1d_r[15];
        default:   sel = m15;
      endcase
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        if (!c_r[NS].rng || (c_r[NS].order == ORD_HIGH)) o_val_r[j] <= '0;
        else o_val_r[j] <= ng_r[15] ? (64'd0 - sel) : sel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) o_rng_r <= c_r[NS].rng;
  end

  assign out_valid    = o_vld_r;
  assign out_in_range = o_rng_r;
  assign out_value_0  = $signed(o_val_r[0]);

  if (DIM > 1) begin : g_out1
    assign out_value_1 = $signed(o_val_r[1]);
  end else begin : g_zero1
    assign out_value_1 = '0;
  end

  if (DIM > 2) begin : g_out2
    assign out_value_2 = $signed(o_val_r[2]);
  end else begin : g_zero2
    assign out_value_2 = '0;
  end

endmodule

// ===== rtl/cubic_bspline_evaluator_unit.sv =====
// Channel   Direction  Handshake               Contents
// in_       input      in_valid / in_ready     load point or evaluate at time
// out_      output     out_valid / out_ready   range flag and three values
// cfg_      input      cfg_valid / cfg_ready   register index and write data
//
// One item per cycle sustained while the output is not stalled; an evaluation passes through
// two front-end stages, one queue slot, fifteen back-end stages set by the weight,
// multiply-accumulate, divide and two rate-scaling steps, and the output register.
// Reset is synchronous and needs no clearing pass; control points are valid once loaded.
// A stalled output freezes the back end; the front end keeps taking items while the
// four-entry queue has room.
//
// Top level of the cubic B-spline evaluator; holds the configuration registers.
// Depends on cbe_pkg, cbe_front, cbe_queue and cbe_back.
module cubic_bspline_evaluator_unit import cbe_pkg::*; #(
  parameter int MAX_POINTS = 256,
  parameter int DIM        = 3
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_cmd,
  input  logic [7:0]         in_point_index,
  input  logic signed [31:0] in_coord_0,
  input  logic signed [31:0] in_coord_1,
  input  logic signed [31:0] in_coord_2,
  input  logic signed [47:0] in_sample_time,
  input  logic [1:0]         in_deriv_order,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_in_range,
  output logic signed [63:0] out_value_0,
  output logic signed [63:0] out_value_1,
  output logic signed [63:0] out_value_2,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [47:0]        cfg_data
);

  logic signed [47:0] start_r;
  logic [31:0]        rate_r;
  logic [8:0]         count_r;
  logic [QCNT_W-1:0]  q_count;
  logic               q_push;
  logic               q_pop;
  qent_t              q_in;
  qent_t              q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      rate_r  <= 32'd65536;
      count_r <= 9'd4;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_START: start_r <= $signed(cfg_data);
        REG_RATE:  rate_r  <= cfg_data[31:0];
        REG_COUNT: count_r <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  cbe_front #(.MAX_POINTS(MAX_POINTS)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_point_index (in_point_index),
    .in_coord_0     (in_coord_0),
    .in_coord_1     (in_coord_1),
    .in_coord_2     (in_coord_2),
    .in_sample_time (in_sample_time),
    .in_deriv_order (in_deriv_order),
    .start_time     (start_r),
    .knot_rate      (rate_r),
    .point_count    (count_r),
    .q_count        (q_count),
    .q_push         (q_push),
    .q_data         (q_in)
  );

  cbe_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .count     (q_count)
  );

  cbe_back #(.MAX_POINTS(MAX_POINTS), .DIM(DIM)) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_count      (q_count),
    .q_data       (q_head),
    .q_pop        (q_pop),
    .knot_rate    (rate_r),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_in_range (out_in_range),
    .out_value_0  (out_value_0),
    .out_value_1  (out_value_1),
    .out_value_2  (out_value_2)
  );

endmodule
